// ===== sv/first_fit_heap_allocator_assert.svh =====
// Assertion macros used by the checker of the heap allocator.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ffha_pkg.sv =====
// Shared types and constants of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_UNITS = 1024;
	localparam int UNIT_AW    = 10;   // chunk index width
	localparam int UNITS_W    = 11;   // chunk size width
	localparam int IDX_W      = 12;   // index sum width (index + size)
	localparam int SUM_W      = 13;   // index + size + size
	localparam int SIZE_W     = 16;
	localparam int ROUND_BYTES = 31;
	localparam int UNIT_SHIFT  = 5;
	localparam int HEAP_MIN    = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic ST_DONE = 1'b0;
	localparam logic ST_OOM  = 1'b1;

	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] REG_HEAP_UNITS = 2'd0;

	// Classified command, as queued between front and back
	typedef struct packed {
		logic               is_alloc;
		logic               ignore;     // free that touches nothing
		logic [IDX_W-1:0]   need;       // units wanted by an allocate
		logic [UNIT_AW-1:0] chunk;      // header index of a free
	} cmd_t;

	// Head of the command queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} qhead_t;

	// Back-end status seen by the front
	typedef struct packed {
		logic clearing;
	} eng_status_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE,
		S_AL_RD, S_AL_CHK, S_AL_RDN, S_AL_N, S_AL_W1, S_AL_W2, S_AL_W3,
		S_FR_RDC, S_FR_WC, S_FR_RDN, S_FR_N, S_FR_RDP, S_FR_P, S_FR_RDPP, S_FR_PP
	} eng_state_t;

endpackage

// ===== sv/ffha_if.sv =====
// Request and response channel interfaces of the heap allocator.
interface ffha_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [ffha_pkg::SIZE_W-1:0]   size_bytes;
	logic [ffha_pkg::UNIT_AW-1:0]  freed_unit;

	modport source (output valid, operation, size_bytes, freed_unit, input ready);
	modport sink   (input valid, operation, size_bytes, freed_unit, output ready);
endinterface

interface ffha_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffha_pkg::UNIT_AW-1:0]  granted_unit;
	logic                          status;

	modport source (output valid, granted_unit, status, input ready);
	modport sink   (input valid, granted_unit, status, output ready);
endinterface

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator with coalescing over 32-byte units.
//
// req: a word with operation (allocate or free), size_bytes and freed_unit.
// rsp: one word per request: granted_unit and status (out of memory).
// Both channels move a word when valid and ready are both high.
// APB: register 0 (heap_units) at address 0; a write re-initializes the heap.
// Requests pass a two-entry queue to a header-walking sequencer, one at a
// time. An allocate reads and then checks each chunk header on the first-fit
// walk, then updates headers; a free reads and updates headers, or answers
// from idle when it names no chunk below the tail.
// The walk rate is set by the single read port of the header stores.
// A new request starts only once the previous response has been taken, so
// a stalled receiver holds the sequencer; up to two more requests queue.
// After reset and after each heap_units write, a clearing sweep writes all
// 1024 header entries; req.ready is low meanwhile.
module first_fit_heap_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	ffha_req_if.sink                      req,
	ffha_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ffha_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int UW = ffha_pkg::UNITS_W;

	logic [UW-1:0]               heap_units_q;
	logic [UW-1:0]               wval;
	logic                        cfg_wr;
	logic [ffha_pkg::UNIT_AW-1:0] tail;
	ffha_pkg::qhead_t            head;
	ffha_pkg::eng_status_t       eng_st;
	logic                        pop;

	// Configuration register with clamping
	assign cfg_wr = psel && penable && pwrite && (paddr == ffha_pkg::REG_HEAP_UNITS);

	always_comb begin
		wval = pwdata[UW-1:0];
		if (wval < UW'(ffha_pkg::HEAP_MIN)) wval = UW'(ffha_pkg::HEAP_MIN);
		if (wval > UW'(ffha_pkg::HEAP_UNITS)) wval = UW'(ffha_pkg::HEAP_UNITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_units_q <= UW'(ffha_pkg::HEAP_UNITS);
		end else if (cfg_wr) begin
			heap_units_q <= wval;
		end
	end

	assign tail   = ffha_pkg::UNIT_AW'(heap_units_q - UW'(1));
	assign prdata = (paddr == ffha_pkg::REG_HEAP_UNITS) ? 32'(heap_units_q) : '0;
	assign pready = 1'b1;

	ffha_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req), .tail(tail),
		.eng_st(eng_st), .pop(pop), .head(head));

	ffha_engine u_engine (
		.clk(clk), .arst_n(arst_n), .clr_start(cfg_wr), .heap_units(heap_units_q),
		.tail(tail), .head(head), .pop(pop), .eng_st(eng_st), .rsp(rsp));

endmodule

// ===== sv/ffha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/ffha_front.sv =====
// Front end: accepts request words, classifies them, queues them.
module ffha_front (
	input  logic                          clk,
	input  logic                          arst_n,
	ffha_req_if.sink                      req,
	input  logic [ffha_pkg::UNIT_AW-1:0]  tail,
	input  ffha_pkg::eng_status_t         eng_st,
	input  logic                          pop,
	output ffha_pkg::qhead_t              head
);

	ffha_pkg::cmd_t cmd_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	ffha_pkg::cmd_t cmd_c;
	logic           push;
	logic [16:0]    rounded;
	logic [ffha_pkg::UNIT_AW-1:0] chunk_c;

	assign req.ready = !eng_st.clearing && (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;

	// Classify: units needed for an allocate, header index for a free
	always_comb begin
		rounded         = 17'(req.size_bytes) + 17'(ffha_pkg::ROUND_BYTES);
		chunk_c         = req.freed_unit - 10'd1;
		cmd_c.is_alloc  = (req.operation == ffha_pkg::OP_ALLOC);
		cmd_c.need      = 12'(rounded >> ffha_pkg::UNIT_SHIFT) + 12'd1;
		cmd_c.chunk     = chunk_c;
		cmd_c.ignore    = (req.freed_unit == '0) || (chunk_c >= tail);
	end

	// Two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wp_q] <= cmd_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.cmd   = cmd_q[rp_q];

endmodule

// ===== sv/ffha_engine.sv =====
// Back end: sequencer that walks and rewrites the chunk headers.
module ffha_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr_start,
	input  logic [ffha_pkg::UNITS_W-1:0]  heap_units,
	input  logic [ffha_pkg::UNIT_AW-1:0]  tail,
	input  ffha_pkg::qhead_t              head,
	output logic                          pop,
	output ffha_pkg::eng_status_t         eng_st,
	ffha_rsp_if.source                    rsp
);

	localparam int AW = ffha_pkg::UNIT_AW;
	localparam int UW = ffha_pkg::UNITS_W;
	localparam int IW = ffha_pkg::IDX_W;
	localparam int SW = ffha_pkg::SUM_W;

	ffha_pkg::eng_state_t state_q, state_d;

	logic [IW-1:0] c_q, need_q, r_q, on_q;
	logic [UW-1:0] uc_q, nu_q, ru_q;
	logic [AW-1:0] p_q, cnt_q;
	logic          merge_q;

	logic          rsp_valid_q, rsp_status_q;
	logic [AW-1:0] rsp_granted_q;

	// Header stores
	logic [AW-1:0] raddr;
	logic          u_we, s_we, p_we;
	logic [AW-1:0] u_wa, s_wa, p_wa;
	logic [UW-1:0] u_wd, rd_units;
	logic          s_wd, rd_used;
	logic [AW-1:0] p_wd, rd_prev;

	ffha_ram #(.WIDTH(UW), .DEPTH(ffha_pkg::HEAP_UNITS)) u_units (
		.clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(raddr), .rdata(rd_units));
	ffha_ram #(.WIDTH(1), .DEPTH(ffha_pkg::HEAP_UNITS)) u_used (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(raddr), .rdata(rd_used));
	ffha_ram #(.WIDTH(AW), .DEPTH(ffha_pkg::HEAP_UNITS)) u_prev (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(raddr), .rdata(rd_prev));

	// Derived values
	logic [IW-1:0] tail_x, c_plus_u, r_c, fr_n, fr_idx, pp_idx;
	logic [UW-1:0] ru_c, fr_cu, pp_cu, pp_ucn;
	logic [SW-1:0] w3_idx;
	logic          fit, res_set, res_status;
	logic [AW-1:0] res_granted;

	always_comb begin
		tail_x   = IW'(tail);
		c_plus_u = c_q + IW'(rd_units);
		r_c      = c_q + need_q;
		fit      = !rd_used && (need_q <= IW'(rd_units));
		ru_c     = merge_q ? UW'(on_q - r_q + IW'(nu_q)) : UW'(on_q - r_q);
		w3_idx   = SW'(r_q) + SW'(ru_q);
		fr_n     = c_q + IW'(rd_units);
		fr_cu    = uc_q + rd_units;
		fr_idx   = c_q + IW'(fr_cu);
		pp_cu    = rd_units + uc_q;
		pp_ucn   = (IW'(p_q) == c_q) ? pp_cu : uc_q;
		pp_idx   = c_q + IW'(pp_ucn);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, store accesses, result
	always_comb begin
		state_d     = state_q;
		raddr       = '0;
		u_we = 1'b0; u_wa = '0; u_wd = '0;
		s_we = 1'b0; s_wa = '0; s_wd = 1'b0;
		p_we = 1'b0; p_wa = '0; p_wd = '0;
		pop         = 1'b0;
		res_set     = 1'b0;
		res_status  = ffha_pkg::ST_DONE;
		res_granted = '0;
		unique case (state_q)
			ffha_pkg::S_CLR: begin
				u_we = 1'b1; u_wa = cnt_q;
				u_wd = (cnt_q == '0) ? (heap_units - UW'(1)) : '0;
				s_we = 1'b1; s_wa = cnt_q;
				p_we = 1'b1; p_wa = cnt_q;
				if (cnt_q == AW'(ffha_pkg::HEAP_UNITS - 1)) state_d = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				if (head.valid && !rsp_valid_q) begin
					pop = 1'b1;
					if (head.cmd.is_alloc) begin
						state_d = ffha_pkg::S_AL_RD;
					end else if (head.cmd.ignore) begin
						res_set = 1'b1;
					end else begin
						state_d = ffha_pkg::S_FR_RDC;
					end
				end
			end
			// First-fit walk: read a header, then check it
			ffha_pkg::S_AL_RD: begin
				raddr = c_q[AW-1:0];
				if (c_q >= tail_x) begin
					res_set = 1'b1; res_status = ffha_pkg::ST_OOM;
					state_d = ffha_pkg::S_IDLE;
				end else begin
					state_d = ffha_pkg::S_AL_CHK;
				end
			end
			ffha_pkg::S_AL_CHK: begin
				if (fit) begin
					if ((r_c != c_plus_u) && (c_plus_u < tail_x)) state_d = ffha_pkg::S_AL_RDN;
					else state_d = ffha_pkg::S_AL_W1;
				end else if (rd_units == '0) begin
					res_set = 1'b1; res_status = ffha_pkg::ST_OOM;
					state_d = ffha_pkg::S_IDLE;
				end else begin
					state_d = ffha_pkg::S_AL_RD;
				end
			end
			ffha_pkg::S_AL_RDN: begin
				raddr   = on_q[AW-1:0];
				state_d = ffha_pkg::S_AL_N;
			end
			ffha_pkg::S_AL_N: state_d = ffha_pkg::S_AL_W1;
			// Mark the chunk used, link the remainder back to it
			ffha_pkg::S_AL_W1: begin
				u_we = 1'b1; u_wa = c_q[AW-1:0]; u_wd = need_q[UW-1:0];
				s_we = 1'b1; s_wa = c_q[AW-1:0]; s_wd = 1'b1;
				if ((r_q != on_q) && (r_q <= tail_x)) begin
					p_we = 1'b1; p_wa = r_q[AW-1:0]; p_wd = c_q[AW-1:0];
				end
				if (r_q == on_q) begin
					res_set = 1'b1; res_granted = c_q[AW-1:0] + AW'(1);
					state_d = ffha_pkg::S_IDLE;
				end else begin
					state_d = ffha_pkg::S_AL_W2;
				end
			end
			// Free remainder, possibly absorbing the next free chunk
			ffha_pkg::S_AL_W2: begin
				if (r_q <= tail_x) begin
					u_we = 1'b1; u_wa = r_q[AW-1:0]; u_wd = ru_c;
					s_we = 1'b1; s_wa = r_q[AW-1:0];
				end
				if (on_q <= tail_x) begin
					p_we = 1'b1; p_wa = on_q[AW-1:0]; p_wd = r_q[AW-1:0];
				end
				if (merge_q) begin
					state_d = ffha_pkg::S_AL_W3;
				end else begin
					res_set = 1'b1; res_granted = c_q[AW-1:0] + AW'(1);
					state_d = ffha_pkg::S_IDLE;
				end
			end
			ffha_pkg::S_AL_W3: begin
				if (w3_idx <= SW'(tail)) begin
					p_we = 1'b1; p_wa = w3_idx[AW-1:0]; p_wd = r_q[AW-1:0];
				end
				res_set = 1'b1; res_granted = c_q[AW-1:0] + AW'(1);
				state_d = ffha_pkg::S_IDLE;
			end
			// Free: clear used mark
			ffha_pkg::S_FR_RDC: begin
				raddr   = c_q[AW-1:0];
				state_d = ffha_pkg::S_FR_WC;
			end
			ffha_pkg::S_FR_WC: begin
				s_we = 1'b1; s_wa = c_q[AW-1:0];
				state_d = (fr_n < tail_x) ? ffha_pkg::S_FR_RDN : ffha_pkg::S_FR_RDP;
			end
			ffha_pkg::S_FR_RDN: begin
				raddr   = on_q[AW-1:0];
				state_d = ffha_pkg::S_FR_N;
			end
			// Merge with the next chunk if free
			ffha_pkg::S_FR_N: begin
				if (!rd_used) begin
					u_we = 1'b1; u_wa = c_q[AW-1:0]; u_wd = fr_cu;
					if (fr_idx <= tail_x) begin
						p_we = 1'b1; p_wa = fr_idx[AW-1:0]; p_wd = c_q[AW-1:0];
					end
				end
				state_d = ffha_pkg::S_FR_RDP;
			end
			ffha_pkg::S_FR_RDP: begin
				raddr   = c_q[AW-1:0];
				state_d = ffha_pkg::S_FR_P;
			end
			ffha_pkg::S_FR_P: begin
				if ((c_q != '0) && (IW'(rd_prev) < tail_x)) begin
					state_d = ffha_pkg::S_FR_RDPP;
				end else begin
					res_set = 1'b1;
					state_d = ffha_pkg::S_IDLE;
				end
			end
			ffha_pkg::S_FR_RDPP: begin
				raddr   = p_q;
				state_d = ffha_pkg::S_FR_PP;
			end
			// Merge into the previous chunk if free
			ffha_pkg::S_FR_PP: begin
				if (!rd_used) begin
					u_we = 1'b1; u_wa = p_q; u_wd = pp_cu;
					if (pp_idx <= tail_x) begin
						p_we = 1'b1; p_wa = pp_idx[AW-1:0]; p_wd = p_q;
					end
				end
				res_set = 1'b1;
				state_d = ffha_pkg::S_IDLE;
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
		if (clr_start) state_d = ffha_pkg::S_CLR;
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ffha_pkg::S_IDLE: begin
				need_q <= head.cmd.need;
				c_q    <= head.cmd.is_alloc ? '0 : IW'(head.cmd.chunk);
			end
			ffha_pkg::S_AL_CHK: begin
				merge_q <= 1'b0;
				on_q    <= c_plus_u;
				r_q     <= r_c;
				if (!fit) c_q <= c_plus_u;
			end
			ffha_pkg::S_AL_N: begin
				merge_q <= !rd_used;
				nu_q    <= rd_units;
			end
			ffha_pkg::S_AL_W2: ru_q <= ru_c;
			ffha_pkg::S_FR_WC: begin
				uc_q <= rd_units;
				on_q <= fr_n;
			end
			ffha_pkg::S_FR_N: if (!rd_used) uc_q <= fr_cu;
			ffha_pkg::S_FR_P: p_q <= rd_prev;
			default: ;
		endcase
	end

	// Clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr_start) begin
			cnt_q <= '0;
		end else if (state_q == ffha_pkg::S_CLR) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_set) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_set) begin
			rsp_granted_q <= res_granted;
			rsp_status_q  <= res_status;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.granted_unit = rsp_granted_q;
	assign rsp.status       = rsp_status_q;
	assign eng_st.clearing  = (state_q == ffha_pkg::S_CLR);

endmodule

// ===== sv/ffha_checker.sv =====
// Port-level checker for the heap allocator, bound to the top level.
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_status,
	input logic [ffha_pkg::UNIT_AW-1:0]  rsp_granted,
	input logic                          cfg_wr
);

	// A response not taken stays offered
	`FFHA_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")

	// A failed allocate grants nothing
	`FFHA_ASSERT_IMP(a_oom_zero, clk, arst_n, rsp_valid && rsp_status, rsp_granted == '0, "oom grant")

	// A heap size write starts the clearing sweep, which blocks requests
	`FFHA_ASSERT_NXT(a_cfg_clear, clk, arst_n, cfg_wr, !req_ready, "no clear after cfg")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n), .req_ready(req.ready), .rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready), .rsp_status(rsp.status), .rsp_granted(rsp.granted_unit),
	.cfg_wr(psel && penable && pwrite && (paddr == ffha_pkg::REG_HEAP_UNITS)));
